// File: src/cdq_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STS_W  = 2;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] NEG_ONE   = {DATA_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE       = 2'd0,
    STS_PUSH_FULL  = 2'd1,
    STS_POP_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_FETCH = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic fetch;
    logic load_out;
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } cdq_sts_t;

endpackage

`default_nettype wire

// File: src/cdq_cmd_if.sv
// Request channel: operation code and data word.
`default_nettype none

interface cdq_cmd_if import cdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// File: src/cdq_rsp_if.sv
// Response channel: popped word, status and deque snapshot.
`default_nettype none

interface cdq_rsp_if import cdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STS_W-1:0]         status;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;
  logic [CAP_W-1:0]         count;

  modport source (output valid, output popped_value, output status, output front_value,
                  output rear_value, output is_empty, output is_full, output count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input front_value,
                  input rear_value, input is_empty, input is_full, input count,
                  output ready);
endinterface

`default_nettype wire

// File: src/circular_deque.sv
// Top level of the circular deque: controller plus datapath.
//
//  channel   dir  handshake          word
//  cmd_i     in   valid/ready        op, value
//  rsp_o     out  valid/ready        popped_value, status, front_value, rear_value,
//                                    is_empty, is_full, count
//  cfg       in   cfg_we_i           cfg_wdata_i = capacity
//
// Each word passes through accept, execute (index update, slot write,
// popped-slot read), fetch (front and rear reads) and deliver into the result
// register. The single ring store and its registered read ports set the pace.
// The result register lets the next word be taken while a result waits; a
// stalled rsp_o holds the sequencer in its deliver step. Reset empties the
// deque and sets the capacity to 16; a capacity write also empties it.
`default_nettype none

module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  cdq_cmd_if.sink               cmd_i,
  cdq_rsp_if.source             rsp_o
);

  cdq_cmd_t cmd;
  cdq_sts_t sts;
  logic     in_ready;

  // sequencer
  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign cmd_i.ready = in_ready;

  // storage, index arithmetic, result register
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_op_i     (cmd_i.op),
    .in_value_i  (cmd_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: src/cdq_ctrl.sv
// Sequencer for the deque: accept, execute, fetch ends, deliver.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire cdq_sts_t sts_i,
  output cdq_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC:  state_d = ST_FETCH;
      ST_FETCH: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_FETCH: cmd_o.fetch = 1'b1;
      ST_DONE:  cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/cdq_dp.sv
// Deque datapath: ring store, head/tail/count, capacity and result register.
`default_nettype none

module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic [OP_W-1:0]   in_op_i,
  input  wire logic [DATA_W-1:0] in_value_i,
  input  wire cdq_cmd_t          cmd_i,
  output cdq_sts_t               sts_o,
  cdq_rsp_if.source              rsp_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int XW = IW + CAP_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [CAP_W-1:0]  cap_q;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CAP_W-1:0]  cnt_q, cnt_d;
  status_e           sts_q, sts_d;
  logic              pop_ok_q, pop_ok_d;
  logic [DATA_W-1:0] popped_q;

  logic              wr_en;
  logic [IW-1:0]     wr_addr, rd_addr_a;
  logic [XW-1:0]     cap_eff;

  logic              out_valid_q;
  logic [DATA_W-1:0] o_pop_q, o_front_q, o_rear_q;
  logic [STS_W-1:0]  o_sts_q;
  logic              o_empty_q, o_full_q;
  logic [CAP_W-1:0]  o_cnt_q;

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = XW'(1);
    end else if (XW'(cap_q) > XW'(DEPTH)) begin
      cap_eff = XW'(DEPTH);
    end else begin
      cap_eff = XW'(cap_q);
    end
  end

  function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i, input logic [XW-1:0] c);
    logic [XW-1:0] nx;
    nx = XW'(i) + XW'(1);
    return (nx >= c) ? '0 : nx[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i, input logic [XW-1:0] c);
    logic [XW-1:0] lst;
    lst = c - XW'(1);
    return (i == '0) ? lst[IW-1:0] : i - IW'(1);
  endfunction

  // one operation against the current indices
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    sts_d     = STS_DONE;
    pop_ok_d  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_addr_a = head_q;
    case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (XW'(cnt_q) >= cap_eff) begin
          sts_d = STS_PUSH_FULL;
        end else if (cnt_q == '0) begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = CAP_W'(1);
          wr_en  = 1'b1;
        end else if (op_q == OP_PUSH_FRONT) begin
          head_d  = step_back(head_q, cap_eff);
          wr_addr = head_d;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CAP_W'(1);
        end else begin
          tail_d  = step_fwd(tail_q, cap_eff);
          wr_addr = tail_d;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CAP_W'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (cnt_q == '0) begin
          sts_d = STS_POP_EMPTY;
        end else begin
          pop_ok_d  = 1'b1;
          cnt_d     = cnt_q - CAP_W'(1);
          rd_addr_a = (op_q == OP_POP_FRONT) ? head_q : tail_q;
          if (cnt_d == '0) begin
            head_d = '0;
            tail_d = '0;
          end else if (op_q == OP_POP_FRONT) begin
            head_d = step_fwd(head_q, cap_eff);
          end else begin
            tail_d = step_back(tail_q, cap_eff);
          end
        end
      end
      default: ;  // query and unused codes
    endcase
  end

  // ring store, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem_q[wr_addr] <= val_q;
    if (cmd_i.exec) begin
      rd_a_q <= mem_q[rd_addr_a];
    end else if (cmd_i.fetch) begin
      rd_a_q <= mem_q[head_q];
      rd_b_q <= mem_q[tail_q];
    end
  end

  // payload latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= in_op_i;
      val_q <= in_value_i;
    end
    if (cmd_i.fetch) popped_q <= rd_a_q;
    if (cmd_i.load_out) begin
      o_pop_q   <= pop_ok_q ? popped_q : NEG_ONE;
      o_sts_q   <= sts_q;
      o_front_q <= (cnt_q == '0) ? NEG_ONE : rd_a_q;
      o_rear_q  <= (cnt_q == '0) ? NEG_ONE : rd_b_q;
      o_empty_q <= (cnt_q == '0);
      o_full_q  <= (XW'(cnt_q) == cap_eff);
      o_cnt_q   <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      sts_q       <= STS_DONE;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q  <= cfg_wdata_i;
        head_q <= '0;
        tail_q <= '0;
        cnt_q  <= '0;
      end else if (cmd_i.exec) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (cmd_i.exec) begin
        sts_q    <= sts_d;
        pop_ok_q <= pop_ok_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = o_pop_q;
  assign rsp_o.status       = o_sts_q;
  assign rsp_o.front_value  = o_front_q;
  assign rsp_o.rear_value   = o_rear_q;
  assign rsp_o.is_empty     = o_empty_q;
  assign rsp_o.is_full      = o_full_q;
  assign rsp_o.count        = o_cnt_q;

endmodule

`default_nettype wire
